@@ hw/rtl/losu_pkg.sv @@
// shared types and constants for the latency order statistics unit
// no dependencies
package losu_pkg;

  localparam int OUT_BITS = 32;
  localparam int STAT_BITS = 40;
  localparam int WIDE_BITS = 128;
  localparam int ROOT_BITS = 64;

  typedef struct packed {
    logic shift;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_DRAIN, ST_READ, ST_ACC, ST_MATH, ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE, M_MUL1, M_MUL2, M_SQRT, M_DIV1, M_DIV2, M_DONE
  } math_state_t;

endpackage

@@ hw/rtl/losu_cell.sv @@
// one sorting cell: keeps the smaller value, passes the larger to the next cell
// depends on losu_pkg
module losu_cell import losu_pkg::*; #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cell_ctl_t    ctl,
  input  logic [W-1:0] cin_val,
  input  logic         cin_vld,
  input  logic [W-1:0] rin_val,
  input  logic         rin_vld,
  output logic [W-1:0] val,
  output logic         vld,
  output logic [W-1:0] cout_val,
  output logic         cout_vld
);
  logic [W-1:0] val_r, val_nxt, cval_r, cval_nxt;
  logic         vld_r, vld_nxt, cvld_r, cvld_nxt;

  always_comb begin
    val_nxt  = val_r;
    vld_nxt  = vld_r;
    cval_nxt = cin_val;
    cvld_nxt = 1'b0;
    if (ctl.shift) begin
      val_nxt = rin_val;
      vld_nxt = rin_vld;
    end else if (cin_vld) begin
      if (!vld_r) begin
        val_nxt = cin_val;
        vld_nxt = 1'b1;
      end else if (cin_val < val_r) begin
        val_nxt  = cin_val;
        cval_nxt = val_r;
        cvld_nxt = 1'b1;
      end else begin
        cvld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    cval_r <= cval_nxt;
    if (!rst_n) begin
      vld_r  <= 1'b0;
      cvld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      cvld_r <= cvld_nxt;
    end
  end

  assign val      = val_r;
  assign vld      = vld_r;
  assign cout_val = cval_r;
  assign cout_vld = cvld_r;
endmodule

@@ hw/rtl/losu_chain.sv @@
// row of sorting cells; inserts at the head, shifts out toward the head
// depends on losu_pkg, losu_cell
module losu_chain import losu_pkg::*; #(
  parameter int N = 1024,
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cell_ctl_t    ctl,
  input  logic [W-1:0] ins_val,
  input  logic         ins_vld,
  output logic [W-1:0] head_val
);
  logic [W-1:0] val [N+1];
  logic         vld [N+1];
  logic [W-1:0] cv  [N+1];
  logic         cvl [N+1];

  assign cv[0]  = ins_val;
  assign cvl[0] = ins_vld;
  assign val[N] = '0;
  assign vld[N] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    losu_cell #(.W(W)) u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl),
      .cin_val(cv[i]), .cin_vld(cvl[i]),
      .rin_val(val[i+1]), .rin_vld(vld[i+1]),
      .val(val[i]), .vld(vld[i]),
      .cout_val(cv[i+1]), .cout_vld(cvl[i+1])
    );
  end

  assign head_val = val[0];
endmodule

@@ hw/rtl/losu_math.sv @@
// serial unit for mean and standard deviation: shift-add multiply,
// bitwise integer square root, restoring division; depends on losu_pkg
module losu_math import losu_pkg::*; #(
  parameter int CW = 11,
  parameter int SUMW = 43,
  parameter int QW = 75,
  parameter int FB = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CW-1:0]        n,
  input  logic [SUMW-1:0]      sum,
  input  logic [QW-1:0]        sumsq,
  output logic                 done,
  output logic [STAT_BITS-1:0] mean,
  output logic [STAT_BITS-1:0] sd
);
  localparam int DW = (SUMW + FB > ROOT_BITS) ? SUMW + FB : ROOT_BITS;
  localparam int MBW = (SUMW > CW) ? SUMW : CW;
  localparam int SW = $clog2(DW + 1);

  math_state_t st_r, st_nxt;
  logic [WIDE_BITS-1:0] acc_r, acc_nxt, mc_r, mc_nxt, vr_r, vr_nxt;
  logic [MBW-1:0] mb_r, mb_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [ROOT_BITS+1:0] rem_r, rem_nxt, rtmp, trial;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [DW-1:0] dq_r, dq_nxt;
  logic [CW-1:0] dr_r, dr_nxt;
  logic [CW:0] dt;
  logic [STAT_BITS-1:0] mean_r, mean_nxt, sd_r, sd_nxt;
  logic last_step;

  function automatic logic [STAT_BITS-1:0] sat(input logic [DW-1:0] q);
    return (|q[DW-1:STAT_BITS]) ? '1 : q[STAT_BITS-1:0];
  endfunction

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      M_IDLE: if (start) st_nxt = M_MUL1;
      M_MUL1: if (last_step) st_nxt = M_MUL2;
      M_MUL2: if (last_step) st_nxt = M_SQRT;
      M_SQRT: if (last_step) st_nxt = M_DIV1;
      M_DIV1: if (last_step) st_nxt = M_DIV2;
      M_DIV2: if (last_step) st_nxt = M_DONE;
      M_DONE: st_nxt = M_IDLE;
      default: st_nxt = M_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r; mc_nxt = mc_r; mb_nxt = mb_r; vr_nxt = vr_r;
    rem_nxt = rem_r; root_nxt = root_r; dq_nxt = dq_r; dr_nxt = dr_r;
    mean_nxt = mean_r; sd_nxt = sd_r;
    step_nxt = step_r + 1'b1;
    last_step = 1'b0;
    rtmp  = {rem_r[ROOT_BITS-1:0], vr_r[WIDE_BITS-1 -: 2]};
    trial = {root_r, 2'b01};
    dt    = {dr_r, dq_r[DW-1]};
    unique case (st_r)
      M_IDLE: begin
        acc_nxt = '0;
        mc_nxt = WIDE_BITS'(sumsq);
        mb_nxt = MBW'(n);
        step_nxt = '0;
      end
      M_MUL1, M_MUL2: begin
        if (mb_r[0]) acc_nxt = (st_r == M_MUL1) ? acc_r + mc_r : acc_r - mc_r;
        mc_nxt = mc_r << 1;
        mb_nxt = mb_r >> 1;
        last_step = (st_r == M_MUL1) ? (step_r == SW'(CW - 1)) : (step_r == SW'(SUMW - 1));
        if (last_step) begin
          step_nxt = '0;
          mc_nxt = WIDE_BITS'(sum);
          mb_nxt = MBW'(sum);
          vr_nxt = acc_nxt << (2 * FB);
          rem_nxt = '0;
          root_nxt = '0;
        end
      end
      M_SQRT: begin
        vr_nxt = vr_r << 2;
        if (rtmp >= trial) begin
          rem_nxt = rtmp - trial;
          root_nxt = {root_r[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt = rtmp;
          root_nxt = {root_r[ROOT_BITS-2:0], 1'b0};
        end
        last_step = (step_r == SW'(ROOT_BITS - 1));
        if (last_step) begin
          step_nxt = '0;
          dq_nxt = DW'(root_nxt);
          dr_nxt = '0;
        end
      end
      M_DIV1, M_DIV2: begin
        dq_nxt = dq_r << 1;
        if (dt >= {1'b0, n}) begin
          dr_nxt = CW'(dt - {1'b0, n});
          dq_nxt[0] = 1'b1;
        end else begin
          dr_nxt = CW'(dt);
        end
        last_step = (step_r == SW'(DW - 1));
        if (last_step) begin
          step_nxt = '0;
          dr_nxt = '0;
          if (st_r == M_DIV1) begin
            sd_nxt = sat(dq_nxt);
            dq_nxt = DW'(sum) << FB;
          end else begin
            mean_nxt = sat(dq_nxt);
          end
        end
      end
      default: step_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; mc_r <= mc_nxt; mb_r <= mb_nxt; vr_r <= vr_nxt;
    rem_r <= rem_nxt; root_r <= root_nxt; dq_r <= dq_nxt; dr_r <= dr_nxt;
    mean_r <= mean_nxt; sd_r <= sd_nxt; step_r <= step_nxt;
    if (!rst_n) st_r <= M_IDLE;
    else st_r <= st_nxt;
  end

  assign done = (st_r == M_DONE);
  assign mean = mean_r;
  assign sd   = sd_r;
endmodule

@@ hw/rtl/latency_order_statistics_unit.sv @@
// Latency order statistics unit. Samples are taken one per cycle while the
// unit is loading and sorted on arrival in a row of MAX_SAMPLES insertion
// cells. After the sample marked last, the unit waits for the row to settle,
// shifts the n sorted samples out (picking order statistics and summing
// squares), lets the square sum settle, then runs a serial arithmetic unit
// before the result is offered. Input is held off from the last sample until
// the result is registered.
// depends on losu_pkg, losu_chain, losu_cell, losu_math
module latency_order_statistics_unit import losu_pkg::*; #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // sample
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // min, max, median, p95, p99, p999, mean, stddev, count
  output logic         out_tuser   // overflow
);
  localparam int SB = SAMPLE_BITS;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SB + CW;
  localparam int QW = 2 * SB + CW;
  localparam int IW = CW + 10;

  top_state_t st_r, st_nxt;
  cell_ctl_t ctl;
  logic [SB-1:0] x, head;
  logic acc_in, ins, start, mdone;
  logic [CW-1:0] kept_r, cnt_r;
  logic [SUMW-1:0] sum_r;
  logic [QW-1:0] sumsq_r;
  logic [2*SB-1:0] sq_r;
  logic sqv_r, drop_r;
  logic [SB-1:0] mn_r, mx_r, md_r, p95_r, p99_r, p999_r;
  logic [IW-1:0] kx, nx;
  logic [STAT_BITS-1:0] mean, sd;
  logic out_load;

  assign x = SB'(in_tdata);
  assign acc_in = in_tvalid && in_tready;
  assign ins = acc_in && (kept_r != CW'(MAX_SAMPLES));
  assign kx = IW'(cnt_r);
  assign nx = IW'(kept_r);
  assign out_load = (st_r == ST_OUT) && (!out_tvalid || out_tready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD:  if (acc_in && in_tlast) st_nxt = ST_DRAIN;
      ST_DRAIN: if (cnt_r == kept_r) st_nxt = ST_READ;
      ST_READ:  if (cnt_r == kept_r - 1'b1) st_nxt = ST_ACC;
      ST_ACC:   if (!sqv_r) st_nxt = ST_MATH;
      ST_MATH:  if (mdone) st_nxt = ST_OUT;
      ST_OUT:   if (out_load) st_nxt = ST_LOAD;
      default:  st_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_tready = (st_r == ST_LOAD);
    ctl.shift = (st_r == ST_READ);
    start     = (st_r == ST_ACC) && !sqv_r;
  end

  losu_chain #(.N(MAX_SAMPLES), .W(SB)) u_chain (
    .clk(clk), .rst_n(rst_n), .ctl(ctl),
    .ins_val(x), .ins_vld(ins), .head_val(head)
  );

  losu_math #(.CW(CW), .SUMW(SUMW), .QW(QW), .FB(FRAC_BITS)) u_math (
    .clk(clk), .rst_n(rst_n), .start(start), .n(kept_r), .sum(sum_r),
    .sumsq(sumsq_r), .done(mdone), .mean(mean), .sd(sd)
  );

  always_ff @(posedge clk) begin
    sq_r <= head * head;
    if (st_r == ST_READ) begin
      if (cnt_r == '0) mn_r <= head;
      if (cnt_r == kept_r - 1'b1) mx_r <= head;
      if ((kx << 1) <= nx && nx < (kx << 1) + IW'(2)) md_r <= head;
      if (kx * IW'(100) <= nx * IW'(95) && nx * IW'(95) < kx * IW'(100) + IW'(100))
        p95_r <= head;
      if (kx * IW'(100) <= nx * IW'(99) && nx * IW'(99) < kx * IW'(100) + IW'(100))
        p99_r <= head;
      if (kx * IW'(1000) <= nx * IW'(999) && nx * IW'(999) < kx * IW'(1000) + IW'(1000))
        p999_r <= head;
    end
    if (out_load) begin
      out_tdata <= {5'd0, 11'(kept_r), sd, mean,
                    OUT_BITS'(p999_r), OUT_BITS'(p99_r), OUT_BITS'(p95_r),
                    OUT_BITS'(md_r), OUT_BITS'(mx_r), OUT_BITS'(mn_r)};
      out_tuser <= drop_r;
    end
    if (!rst_n) begin
      st_r <= ST_LOAD;
      kept_r <= '0;
      sum_r <= '0;
      drop_r <= 1'b0;
      cnt_r <= '0;
      sqv_r <= 1'b0;
      sumsq_r <= '0;
      out_tvalid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      sqv_r <= (st_r == ST_READ);
      if (sqv_r) sumsq_r <= sumsq_r + QW'(sq_r);
      if (ins) begin
        kept_r <= kept_r + 1'b1;
        sum_r <= sum_r + SUMW'(x);
      end else if (acc_in) begin
        drop_r <= 1'b1;
      end
      if (st_r == ST_LOAD) begin
        cnt_r <= '0;
        sumsq_r <= '0;
      end else if (st_r == ST_DRAIN) begin
        cnt_r <= (cnt_r == kept_r) ? '0 : cnt_r + 1'b1;
      end else if (st_r == ST_READ) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (out_load) begin
        out_tvalid <= 1'b1;
        kept_r <= '0;
        sum_r <= '0;
        drop_r <= 1'b0;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= CW'(MAX_SAMPLES)) else $error("kept count beyond capacity");
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_tlast) |=> (st_r == ST_DRAIN && !in_tready))
    else $error("last transfer did not close the set");
  a_done_in_math: assert property (@(posedge clk) disable iff (!rst_n)
    mdone |-> (st_r == ST_MATH)) else $error("math done outside math phase");
  a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_READ) |-> (kept_r != '0)) else $error("readout of empty set");
endmodule

@@ tb/losu_checker.sv @@
// checker for the latency order statistics unit: watches both stream channels,
// predicts each result from the accepted samples and compares it field by field
// depends on losu_pkg and the port layout of latency_order_statistics_unit
`timescale 1ns / 100ps
module losu_checker import losu_pkg::*; #(
  parameter int CAPACITY = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [31:0]  in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [287:0] out_tdata,
  input  logic         out_tuser,
  output int           errors,
  output int           pending
);

  typedef struct {
    logic [31:0]        min_v;
    logic [31:0]        max_v;
    logic [31:0]        median_v;
    logic [31:0]        p95_v;
    logic [31:0]        p99_v;
    logic [31:0]        p999_v;
    logic [STAT_BITS-1:0] mean_v;
    logic [STAT_BITS-1:0] sdev_v;
    logic [10:0]        count_v;
    logic               ovf_v;
  } stats_t;

  logic [31:0]  kept_q[$];
  logic [41:0]  kept_sum;
  logic         dropped;
  stats_t       stats_q[$];

  function automatic logic [63:0] isqrt128(logic [127:0] a);
    logic [63:0]  root;
    logic [63:0]  cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= a) root = cand;
    end
    return root;
  endfunction

  function automatic stats_t close_set(logic [31:0] vals[$], logic [41:0] sum, logic ovf);
    stats_t       s;
    int unsigned  n;
    logic [127:0] sumsq;
    logic [127:0] spread;
    logic [63:0]  root;
    logic [63:0]  mean;
    n = vals.size();
    vals.sort();
    sumsq = '0;
    foreach (vals[i]) sumsq += 128'(vals[i]) * 128'(vals[i]);
    mean = (64'(sum) << 8) / n;
    spread = (128'(n) * sumsq - 128'(sum) * 128'(sum)) << 16;
    root = isqrt128(spread) / n;
    s.min_v = vals[0];
    s.max_v = vals[n-1];
    s.median_v = vals[n/2];
    s.p95_v = vals[(n*95)/100];
    s.p99_v = vals[(n*99)/100];
    s.p999_v = vals[(n*999)/1000];
    s.mean_v = (mean >> STAT_BITS) != 0 ? '1 : mean[STAT_BITS-1:0];
    s.sdev_v = (root >> STAT_BITS) != 0 ? '1 : root[STAT_BITS-1:0];
    s.count_v = 11'(n);
    s.ovf_v = ovf;
    return s;
  endfunction

  task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h actual %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  assign pending = stats_q.size();

  initial begin
    errors = 0;
    kept_sum = '0;
    dropped = 1'b0;
  end

  always @(posedge clk) begin
    stats_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (stats_q.size() == 0) begin
          $error("result transfer with no result expected");
          errors++;
        end else begin
          e = stats_q.pop_front();
          cmp("min_value", e.min_v, out_tdata[31:0]);
          cmp("max_value", e.max_v, out_tdata[63:32]);
          cmp("median_value", e.median_v, out_tdata[95:64]);
          cmp("p95_value", e.p95_v, out_tdata[127:96]);
          cmp("p99_value", e.p99_v, out_tdata[159:128]);
          cmp("p999_value", e.p999_v, out_tdata[191:160]);
          cmp("mean_q8", e.mean_v, out_tdata[231:192]);
          cmp("stddev_q8", e.sdev_v, out_tdata[271:232]);
          cmp("sample_count", e.count_v, out_tdata[282:272]);
          cmp("pad", 0, out_tdata[287:283]);
          cmp("overflow", e.ovf_v, out_tuser);
        end
      end
      if (in_tvalid && in_tready) begin
        if (kept_q.size() < CAPACITY) begin
          kept_q.push_back(in_tdata);
          kept_sum += 42'(in_tdata);
        end else begin
          dropped = 1'b1;
        end
        if (in_tlast) begin
          stats_q.push_back(close_set(kept_q, kept_sum, dropped));
          kept_q.delete();
          kept_sum = '0;
          dropped = 1'b0;
        end
      end
    end
  end

endmodule

@@ tb/latency_order_statistics_unit_tb.sv @@
// top of the latency order statistics testbench: clock, reset, sample sets
// with random idling, result back-pressure and a watchdog
// depends on latency_order_statistics_unit and losu_checker
`timescale 1ns / 100ps
module latency_order_statistics_unit_tb;

  localparam int CAPACITY = 1024;
  localparam int IDLE_LIMIT = 50000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;
  logic         out_tuser;
  int           errors;
  int           pending;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           quiet_cycles;

  latency_order_statistics_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  losu_checker #(.CAPACITY(CAPACITY)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no transfer on either channel
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_sample(logic [31:0] s, logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= s;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(5))
      0: return $urandom_range(255);
      1: return 32'hFFFF_FFFF - $urandom_range(15);
      2: return $urandom_range(15);
      3: return 32'd1000 + $urandom_range(9000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) send_sample(pick_sample(), i == n - 1);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int set_n;
    int sent;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-sample sets at both extremes, then small sets with ties and extremes
    send_sample(32'h0, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h7, 1'b0);
    send_sample(32'h7, 1'b0);
    send_sample(32'h7, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'hAAAA_AAAA, 1'b1);
    drain();

    // full store, then samples dropped, the last one included
    for (int i = 0; i < CAPACITY + 3; i++) send_sample($urandom, i == CAPACITY + 2);
    drain();

    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      while (sent < (ph + 1) * 80) begin
        set_n = ($urandom_range(9) == 0) ? $urandom_range(150, 40) : $urandom_range(12, 1);
        send_set(set_n);
        sent += set_n;
        if ($urandom_range(7) == 0) drain();
      end
    end

    drain();
    repeat (3000) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
